// ===== rtl/pans_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pans_pkg
// Shared widths and result codes of the periodic average noise subtractor.
// ----------------------------------------------------------------------------
package pans_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 17;
  localparam int LEN_W    = 17;

  typedef enum logic [2:0] {
    ST_RECORDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_PLAYED    = 3'd2,
    ST_ENDED     = 3'd3,
    ST_NOT_READY = 3'd4
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/periodic_average_noise_subtract.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_average_noise_subtract
// Records a block of samples with per-phase sums, then plays it back with
// the phase average removed.
// ----------------------------------------------------------------------------
// Use: an item is taken at a clock edge with start high and busy low.
// req_type 0 records sample (zero if sample_missing), req_type 1 is a
// playback tick. Each item gives one result on out_sample/status, shown for
// exactly one cycle with done high; the receiver cannot stall it.
// Steps from the accept edge to the cycle done is high:
//   record item stored:            sum read, then write back
//   full / not ready / ended:      done set at the accept edge
//   played tick:                   store and sum read, bit-serial divide
//                                  over NUMW bits (23 at default sizes),
//                                  then output; no divide with no whole period
// The next item is accepted in the cycle done shows the previous result.
// Configuration: cfg_data is taken on cfg_valid & cfg_ready, ready only when
// idle; the block then stays busy while a reciprocal multiply and
// one correction step work out the whole-period count of the new length.
// Reset clears indexes and control state and restores the length 65536
// (limited to RECORD_DEPTH). The phase sums need no clearing pass: each
// entry is written during the first period of recording.
// ----------------------------------------------------------------------------
module periodic_average_noise_subtract
  import pans_pkg::*;
#(
  parameter int PERIOD       = 1024,
  parameter int RECORD_DEPTH = 65536
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       sample_missing,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic        [LEN_W-1:0]    cfg_data,
  output logic                            done,
  output logic signed [OUT_W-1:0]         out_sample,
  output status_t                         status
);

  localparam int IW    = $clog2(RECORD_DEPTH + 1);
  localparam int AW    = $clog2(RECORD_DEPTH);
  localparam int PW    = $clog2(PERIOD);
  localparam int PCW   = $clog2(PERIOD + 1);
  localparam int NPRAW = $clog2(RECORD_DEPTH / PERIOD + 1);
  localparam int NPW   = (NPRAW > 0) ? NPRAW : 1;
  localparam int SUMW  = SAMPLE_W + $clog2(RECORD_DEPTH / PERIOD) + 1;
  localparam int NUMW  = (SUMW > IW) ? SUMW : IW;
  localparam int DVW   = (NPW > PCW) ? NPW : PCW;
  localparam int CW    = (IW > LEN_W) ? IW : LEN_W;
  localparam int CNTW  = $clog2(NUMW);
  localparam int PRW   = IW + NPW;

  localparam int RST_LEN     = (65536 > RECORD_DEPTH) ? RECORD_DEPTH : 65536;
  localparam int RST_PERIODS = RST_LEN / PERIOD;
  localparam int RST_WHOLE   = RST_PERIODS * PERIOD;

  localparam logic [IW-1:0]   PERIOD_IW = IW'(PERIOD);
  localparam logic [PW-1:0]   PH_LAST   = PW'(PERIOD - 1);
  localparam logic [CW-1:0]   DEPTH_CW  = CW'(RECORD_DEPTH);
  localparam logic [CNTW-1:0] CNT_LOAD  = CNTW'(NUMW - 1);
  // floor(2^IW / PERIOD): the estimate is the true count or one below it
  localparam logic [IW-1:0]   RECIP     = IW'((1 << IW) / PERIOD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_TRD,
    S_DIV,
    S_CFGMUL,
    S_CFGFIX,
    S_TOUT
  } state_t;

  state_t state;

  // indexes and length bookkeeping
  logic [IW-1:0]  record_index;
  logic [IW-1:0]  play_index;
  logic [PW-1:0]  rec_phase;
  logic [PW-1:0]  play_phase;
  logic           first_lap;
  logic [IW-1:0]  eff_len;
  logic [NPW-1:0] periods;
  logic [IW-1:0]  whole;

  // per-item holding registers
  logic signed [SAMPLE_W-1:0] s_q;
  logic                       add_q;
  logic signed [SAMPLE_W-1:0] samp_q;
  logic                       neg_q;

  // bit-serial divider for the phase average
  logic [NUMW-1:0] num;
  logic [DVW-1:0]  dvs;
  logic [DVW-1:0]  rem;
  logic [CNTW-1:0] cnt;

  // whole-period count of a new length
  logic [PRW-1:0] len_prod;
  logic [NPW-1:0] q_est;
  logic [IW-1:0]  whole_est;
  logic [IW-1:0]  len_left;

  // memories
  logic signed [SAMPLE_W-1:0] rec_mem [RECORD_DEPTH];
  logic signed [SUMW-1:0]     sum_mem [PERIOD];
  logic signed [SAMPLE_W-1:0] st_rdata;
  logic signed [SUMW-1:0]     sm_rdata;

  logic                       accept;
  logic                       rec_open;
  logic                       play_ok;
  logic                       st_we;
  logic                       st_re;
  logic signed [SAMPLE_W-1:0] s_in;
  logic                       sm_re;
  logic [PW-1:0]              sm_raddr;
  logic                       sm_we;
  logic signed [SUMW-1:0]     sm_wdata;
  logic [CW-1:0]              len_x;
  logic [IW-1:0]              eff_len_next;
  logic [DVW:0]               trial;
  logic                       trial_ge;
  logic [SUMW-1:0]            sum_mag;
  logic signed [OUT_W-1:0]    avg;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign accept    = start && !busy;
  assign rec_open  = (record_index < eff_len);
  assign play_ok   = !rec_open && (play_index < eff_len);
  assign s_in      = sample_missing ? '0 : sample;

  always_comb begin
    st_we    = accept && !req_type && rec_open;
    st_re    = accept && req_type && play_ok;
    sm_re    = accept && (req_type ? play_ok : rec_open);
    sm_raddr = req_type ? play_phase : rec_phase;
    sm_we    = (state == S_REC) && (add_q || first_lap);
    // first visit of a phase starts from zero instead of the unwritten entry
    sm_wdata = (first_lap ? '0 : sm_rdata)
             + (add_q ? SUMW'(s_q) : '0);
  end

  always_comb begin
    len_x = CW'(cfg_data);
    if (len_x == '0) begin
      len_x = CW'(1);
    end
    if (len_x > DEPTH_CW) begin
      len_x = DEPTH_CW;
    end
    eff_len_next = IW'(len_x);
  end

  always_comb begin
    q_est     = len_prod[IW +: NPW];
    whole_est = IW'(q_est) * PERIOD_IW;
    len_left  = eff_len - whole_est;
  end

  always_comb begin
    trial    = {rem, num[NUMW-1]};
    trial_ge = (trial >= {1'b0, dvs});
    sum_mag  = sm_rdata[SUMW-1] ? SUMW'(-sm_rdata) : SUMW'(sm_rdata);
    avg      = neg_q ? -$signed(num[OUT_W-1:0]) : $signed(num[OUT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      rec_mem[record_index[AW-1:0]] <= s_in;
    end
    if (st_re) begin
      st_rdata <= rec_mem[play_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sum_mem[rec_phase] <= sm_wdata;
    end
    if (sm_re) begin
      sm_rdata <= sum_mem[sm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      record_index <= '0;
      play_index   <= '0;
      rec_phase    <= '0;
      play_phase   <= '0;
      first_lap    <= 1'b1;
      eff_len      <= IW'(RST_LEN);
      periods      <= NPW'(RST_PERIODS);
      whole        <= IW'(RST_WHOLE);
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            out_sample <= '0;
            if (!req_type) begin
              if (rec_open) begin
                s_q   <= s_in;
                add_q <= (record_index < whole);
                state <= S_REC;
              end else begin
                status <= ST_FULL;
                done   <= 1'b1;
              end
            end else if (rec_open) begin
              status <= ST_NOT_READY;
              done   <= 1'b1;
            end else if (!play_ok) begin
              status <= ST_ENDED;
              done   <= 1'b1;
            end else begin
              state <= S_TRD;
            end
          end else if (cfg_valid) begin
            eff_len <= eff_len_next;
            state   <= S_CFGMUL;
          end
        end
        S_REC: begin
          out_sample   <= '0;
          status       <= ST_RECORDED;
          done         <= 1'b1;
          record_index <= record_index + IW'(1);
          if (rec_phase == PH_LAST) begin
            rec_phase <= '0;
            first_lap <= 1'b0;
          end else begin
            rec_phase <= rec_phase + PW'(1);
          end
          state <= S_IDLE;
        end
        S_TRD: begin
          samp_q <= st_rdata;
          neg_q  <= sm_rdata[SUMW-1];
          rem    <= '0;
          cnt    <= CNT_LOAD;
          dvs    <= DVW'(periods);
          if (periods == '0) begin
            num   <= '0;
            state <= S_TOUT;
          end else begin
            num   <= NUMW'(sum_mag);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (trial_ge) begin
            rem <= DVW'(trial - {1'b0, dvs});
          end else begin
            rem <= DVW'(trial);
          end
          num <= {num[NUMW-2:0], trial_ge};
          cnt <= cnt - CNTW'(1);
          if (cnt == '0) begin
            state <= S_TOUT;
          end
        end
        S_CFGMUL: begin
          len_prod <= PRW'(eff_len) * PRW'(RECIP);
          state    <= S_CFGFIX;
        end
        S_CFGFIX: begin
          if (len_left >= PERIOD_IW) begin
            periods <= q_est + NPW'(1);
            whole   <= whole_est + PERIOD_IW;
          end else begin
            periods <= q_est;
            whole   <= whole_est;
          end
          state <= S_IDLE;
        end
        S_TOUT: begin
          // result wraps to the output width
          out_sample <= OUT_W'(samp_q) - avg;
          status     <= ST_PLAYED;
          done       <= 1'b1;
          play_index <= play_index + IW'(1);
          if (play_phase == PH_LAST) begin
            play_phase <= '0;
          end else begin
            play_phase <= play_phase + PW'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !req_type && !rec_open) |=> (done && status == ST_FULL))
    else $error("record into a full store did not report full");

  a_play_advance: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_PLAYED) |-> (play_index == $past(play_index) + IW'(1)))
    else $error("played result without play index advance");

  a_play_behind: assert property (@(posedge clk) disable iff (rst)
    play_index <= record_index)
    else $error("playback passed the recorded samples");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dvs != '0))
    else $error("divider running with zero divisor");
`endif

endmodule
`default_nettype wire
